### rtl/ept_pkg.sv
// ----------------------------------------------------------------------------
// Encoder position and velocity tracker package
// Shared widths, request and register codes, reset values and the structs
// that pass between the tracker and its speed unit.
// ----------------------------------------------------------------------------
package ept_pkg;

  localparam int unsigned FILL_W = 10;
  localparam int unsigned CPR_W  = 24;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned POS_W  = 64;
  localparam int unsigned SUM_W  = CNT_W + FILL_W;
  localparam int unsigned D_W    = FILL_W + CPR_W;
  localparam int unsigned SPD_W  = 32;
  localparam int unsigned Q_W    = SPD_W + 1;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = CPR_W;

  localparam int unsigned TICK_RATE_HZ_DEF = 1000;

  localparam logic [FILL_W-1:0] MAX_WINDOW     = 10'd1000;
  localparam logic [FILL_W-1:0] WINDOW_LEN_RST = 10'd10;
  localparam logic [CPR_W-1:0]  CPR_RST        = 24'd4096;

  localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ZERO = 2'd1;
  localparam logic [REQ_W-1:0] REQ_INIT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV = 1'b1;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  sum;
    logic [FILL_W-1:0] fill;
    logic [CPR_W-1:0]  cpr;
  } spd_req_t;

  typedef struct packed {
    logic             done;
    logic [SPD_W-1:0] speed;
  } spd_rsp_t;

endpackage

### rtl/encoder_position_velocity_tracker_unit.sv
// ----------------------------------------------------------------------------
// Encoder position and velocity tracker
// Tracks a 64-bit position, tick count and windowed speed from a raw
// quadrature counter sampled once per control tick.
// ----------------------------------------------------------------------------
// Each request gives one result. A tick that does not close the velocity
// window, and every other request, has its result loaded into the output
// register at once. A tick that closes the window runs the speed unit: KW
// shift-add steps and SUM_W + KW division steps on the one shared adder,
// where KW is the bit width of TICK_RATE_HZ * 960, then the speed unit's
// done state and the tracker's result state, which loads the output register.
// The input side is stalled while that runs and while a result is held in
// the output register and stalled. Speed is reported in signed 1/16 rpm,
// truncated toward zero and saturated to 32 bits. Configuration writes are
// always ready and must only be made while the block is idle; writing the
// window length clears the window.
module encoder_position_velocity_tracker_unit #(
  parameter int unsigned TICK_RATE_HZ = ept_pkg::TICK_RATE_HZ_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [ept_pkg::REQ_W-1:0]              req_type_i,
  input  logic [ept_pkg::CNT_W-1:0]              counter_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [ept_pkg::POS_W-1:0]       position_o,
  output logic signed [ept_pkg::CNT_W-1:0]       step_delta_o,
  output logic [ept_pkg::CNT_W-1:0]              tick_count_o,
  output logic signed [ept_pkg::SPD_W-1:0]       speed_q4_o,
  output logic                                   speed_updated_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [ept_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [ept_pkg::CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int unsigned FW = ept_pkg::FILL_W;
  localparam int unsigned CW = ept_pkg::CNT_W;
  localparam int unsigned PW = ept_pkg::POS_W;
  localparam int unsigned SW = ept_pkg::SUM_W;
  localparam int unsigned VW = ept_pkg::SPD_W;
  localparam int unsigned RW = ept_pkg::CPR_W;

  typedef enum logic [2:0] {
    T_IDLE   = 3'b001,
    T_CALC   = 3'b010,
    T_RESULT = 3'b100
  } trk_state_e;

  trk_state_e state_q, state_d;
  logic [FW-1:0] win_len_q, win_len_d;
  logic [RW-1:0] cpr_q, cpr_d;
  logic [CW-1:0] prev_q, prev_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [CW-1:0] delta_q, delta_d;
  logic [CW-1:0] tick_q, tick_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [VW-1:0] speed_q, speed_d;

  logic                        out_valid_q, out_valid_d;
  logic signed [PW-1:0]        out_pos_q;
  logic signed [CW-1:0]        out_delta_q;
  logic [CW-1:0]               out_tick_q;
  logic signed [VW-1:0]        out_speed_q;
  logic                        out_upd_q;

  logic          in_acc;
  logic          out_free;
  logic          out_load;
  logic          closes;
  logic [CW-1:0] raw;
  logic [PW-1:0] pos_tick;
  logic [SW-1:0] sum_tick;
  logic [FW-1:0] fill_tick;
  logic [FW-1:0] win_wr;
  logic [RW-1:0] cpr_wr;

  ept_pkg::spd_req_t spd_req;
  ept_pkg::spd_rsp_t spd_rsp;

  ept_speed_unit #(
    .TICK_RATE_HZ(TICK_RATE_HZ)
  ) u_speed (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (spd_req),
    .rsp_o (spd_rsp)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == T_IDLE) && out_free);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign raw       = counter_value_i - prev_q;
  assign pos_tick  = pos_q + {{(PW-CW){raw[CW-1]}}, raw};
  assign sum_tick  = sum_q + {{(SW-CW){raw[CW-1]}}, raw};
  assign fill_tick = fill_q + FW'(1);
  assign closes    = (fill_tick >= win_len_q);

  assign spd_req.start = in_acc && (req_type_i == ept_pkg::REQ_TICK) && closes;
  assign spd_req.sum   = sum_tick;
  assign spd_req.fill  = fill_tick;
  assign spd_req.cpr   = cpr_q;

  always_comb begin
    win_wr = cfg_data_i[FW-1:0];
    if (win_wr == '0) begin
      win_wr = FW'(1);
    end
    if (win_wr > ept_pkg::MAX_WINDOW) begin
      win_wr = ept_pkg::MAX_WINDOW;
    end
    cpr_wr = cfg_data_i[RW-1:0];
    if (cpr_wr == '0) begin
      cpr_wr = RW'(1);
    end
  end

  always_comb begin
    state_d   = state_q;
    win_len_d = win_len_q;
    cpr_d     = cpr_q;
    prev_d    = prev_q;
    pos_d     = pos_q;
    delta_d   = delta_q;
    tick_d    = tick_q;
    sum_d     = sum_q;
    fill_d    = fill_q;
    speed_d   = speed_q;
    out_load  = 1'b0;

    if (in_acc) begin
      out_load = 1'b1;
      case (req_type_i)
        ept_pkg::REQ_TICK: begin
          prev_d  = counter_value_i;
          pos_d   = pos_tick;
          delta_d = raw;
          tick_d  = tick_q + CW'(1);
          if (closes) begin
            sum_d    = '0;
            fill_d   = '0;
            state_d  = T_CALC;
            out_load = 1'b0;
          end else begin
            sum_d  = sum_tick;
            fill_d = fill_tick;
          end
        end
        ept_pkg::REQ_ZERO, ept_pkg::REQ_INIT: begin
          if (req_type_i == ept_pkg::REQ_INIT) begin
            prev_d = counter_value_i;
          end
          pos_d   = '0;
          delta_d = '0;
          tick_d  = '0;
          speed_d = '0;
          sum_d   = '0;
          fill_d  = '0;
        end
        default: begin
          prev_d = prev_q;
        end
      endcase
    end

    case (state_q)
      T_CALC: begin
        if (spd_rsp.done) begin
          speed_d = spd_rsp.speed;
          state_d = T_RESULT;
        end
      end
      T_RESULT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = T_IDLE;
        end
      end
      default: begin
        state_d = state_d;
      end
    endcase

    if (cfg_valid_i) begin
      case (cfg_index_i)
        ept_pkg::CFG_WINDOW_LEN: begin
          win_len_d = win_wr;
          sum_d     = '0;
          fill_d    = '0;
        end
        ept_pkg::CFG_COUNTS_PER_REV: begin
          cpr_d = cpr_wr;
        end
        default: begin
          cpr_d = cpr_q;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      win_len_q   <= ept_pkg::WINDOW_LEN_RST;
      cpr_q       <= ept_pkg::CPR_RST;
      prev_q      <= '0;
      pos_q       <= '0;
      delta_q     <= '0;
      tick_q      <= '0;
      sum_q       <= '0;
      fill_q      <= '0;
      speed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_len_q   <= win_len_d;
      cpr_q       <= cpr_d;
      prev_q      <= prev_d;
      pos_q       <= pos_d;
      delta_q     <= delta_d;
      tick_q      <= tick_d;
      sum_q       <= sum_d;
      fill_q      <= fill_d;
      speed_q     <= speed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pos_q   <= pos_d;
      out_delta_q <= delta_d;
      out_tick_q  <= tick_d;
      out_speed_q <= speed_d;
      out_upd_q   <= (state_q == T_RESULT);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign position_o      = out_pos_q;
  assign step_delta_o    = out_delta_q;
  assign tick_count_o    = out_tick_q;
  assign speed_q4_o      = out_speed_q;
  assign speed_updated_o = out_upd_q;

`ifndef SYNTHESIS
  a_fill_below_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < win_len_q)
    else $error("Window fill reached the window length without closing.");

  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spd_rsp.done |-> state_q == T_CALC)
    else $error("Speed unit finished while no window calculation was pending.");

  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && req_type_i == ept_pkg::REQ_TICK |=> tick_q == $past(tick_q) + CW'(1))
    else $error("Tick transfer did not advance the tick count by one.");

  a_result_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && state_q == T_RESULT |-> fill_q == '0 && sum_q == '0)
    else $error("Speed result left the window accumulators uncleared.");
`endif

endmodule

### rtl/ept_addsub.sv
// ----------------------------------------------------------------------------
// Shared adder and subtractor
// One wide add or subtract; the top result bit is the carry, or the borrow
// when subtracting.
// ----------------------------------------------------------------------------
module ept_addsub #(
  parameter int unsigned W = 69
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W:0]   y_o
);

  always_comb begin
    if (sub_i) begin
      y_o = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      y_o = {1'b0, a_i} + {1'b0, b_i};
    end
  end

endmodule

### rtl/ept_speed_unit.sv
// ----------------------------------------------------------------------------
// Speed unit
// Computes the window speed in 1/16 rpm with one shared adder: a shift-add
// multiply of the count magnitude by the rate constant, then a restoring
// division by window length times counts per revolution, then saturation.
// ----------------------------------------------------------------------------
module ept_speed_unit #(
  parameter int unsigned TICK_RATE_HZ = ept_pkg::TICK_RATE_HZ_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ept_pkg::spd_req_t req_i,
  output ept_pkg::spd_rsp_t rsp_o
);

  localparam logic [63:0] K      = 64'(TICK_RATE_HZ) * 64'd960;
  localparam int unsigned KW     = $clog2(K + 64'd1);
  localparam int unsigned PROD_W = ept_pkg::SUM_W + KW;
  localparam int unsigned ITER_W = $clog2(PROD_W);
  localparam logic [KW-1:0] K_BITS = KW'(K);
  localparam int unsigned SW = ept_pkg::SUM_W;
  localparam int unsigned DW = ept_pkg::D_W;
  localparam int unsigned QW = ept_pkg::Q_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } spd_state_e;

  spd_state_e state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              neg_q, neg_d;
  logic [SW-1:0]     mag_q, mag_d;
  logic [DW-1:0]     div_q, div_d;
  logic [KW-1:0]     kbits_q, kbits_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [DW-1:0]     rem_q, rem_d;
  logic [QW-1:0]     quo_q, quo_d;
  logic              ovf_q, ovf_d;

  logic [PROD_W-1:0] alu_a, alu_b;
  logic              alu_sub;
  logic [PROD_W:0]   alu_y;
  logic [DW:0]       trial;
  logic              borrow;
  logic [QW-1:0]     lim;
  logic [QW-1:0]     sat;

  ept_addsub #(
    .W(PROD_W)
  ) u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .sub_i(alu_sub),
    .y_o  (alu_y)
  );

  assign trial  = {rem_q, acc_q[PROD_W-1]};
  assign borrow = alu_y[PROD_W];
  assign lim    = neg_q ? {2'b01, {(QW-2){1'b0}}} : {2'b00, {(QW-2){1'b1}}};
  assign sat    = (ovf_q || (quo_q > lim)) ? lim : quo_q;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_MUL: begin
        alu_a = {acc_q[PROD_W-2:0], 1'b0};
        alu_b = kbits_q[KW-1] ? PROD_W'(mag_q) : '0;
      end
      S_DIV: begin
        alu_a   = PROD_W'(trial);
        alu_b   = PROD_W'(div_q);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    div_d   = div_q;
    kbits_d = kbits_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    ovf_d   = ovf_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          neg_d   = req_i.sum[SW-1];
          mag_d   = req_i.sum[SW-1] ? (~req_i.sum + SW'(1)) : req_i.sum;
          div_d   = DW'(req_i.fill) * DW'(req_i.cpr);
          acc_d   = '0;
          kbits_d = K_BITS;
          iter_d  = ITER_W'(KW - 1);
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        acc_d   = alu_y[PROD_W-1:0];
        kbits_d = kbits_q << 1;
        if (iter_q == '0) begin
          iter_d  = ITER_W'(PROD_W - 1);
          rem_d   = '0;
          quo_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_DIV;
        end else begin
          iter_d = iter_q - ITER_W'(1);
        end
      end
      S_DIV: begin
        rem_d = borrow ? trial[DW-1:0] : alu_y[DW-1:0];
        acc_d = acc_q << 1;
        quo_d = {quo_q[QW-2:0], ~borrow};
        ovf_d = ovf_q | quo_q[QW-1];
        if (iter_q == '0) begin
          state_d = S_DONE;
        end else begin
          iter_d = iter_q - ITER_W'(1);
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    mag_q   <= mag_d;
    div_q   <= div_d;
    kbits_q <= kbits_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    ovf_q   <= ovf_d;
  end

  assign rsp_o.done  = (state_q == S_DONE);
  assign rsp_o.speed = neg_q ? (~sat[QW-2:0] + (QW-1)'(1)) : sat[QW-2:0];

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Encoder position and velocity tracker testbench
// Drives raw counter samples and zero and init requests through the tracker
// under random bursts and output stalls. Typed rows are checked against fixed
// results, the rest against an in-bench model of position, tick and speed.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [ept_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam longint unsigned SPEED_SCALE = longint'(ept_pkg::TICK_RATE_HZ_DEF) * 960;
  localparam int RANDOM_ITEMS = 850;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int SETTLE       = 150;

  typedef struct {
    logic signed [ept_pkg::POS_W-1:0] position;
    logic signed [ept_pkg::CNT_W-1:0] step_delta;
    logic [ept_pkg::CNT_W-1:0]        tick_count;
    logic signed [ept_pkg::SPD_W-1:0] speed_q4;
    logic                             speed_updated;
  } track_result_t;

  typedef struct {
    bit                             is_cfg;
    logic [ept_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [ept_pkg::CFG_DATA_W-1:0] reg_val;
    logic [ept_pkg::REQ_W-1:0]      req;
    logic [ept_pkg::CNT_W-1:0]      count;
    bit                             typed;
    track_result_t                  res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [ept_pkg::REQ_W-1:0] req_type_i = ept_pkg::REQ_TICK;
  logic [ept_pkg::CNT_W-1:0] counter_value_i = '0;
  logic out_stall_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [ept_pkg::CFG_IDX_W-1:0] cfg_index_i = ept_pkg::CFG_WINDOW_LEN;
  logic [ept_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  logic in_stall_o;
  logic out_valid_o;
  logic signed [ept_pkg::POS_W-1:0] position_o;
  logic signed [ept_pkg::CNT_W-1:0] step_delta_o;
  logic [ept_pkg::CNT_W-1:0] tick_count_o;
  logic signed [ept_pkg::SPD_W-1:0] speed_q4_o;
  logic speed_updated_o;
  logic cfg_ready_o;

  encoder_position_velocity_tracker_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .counter_value_i (counter_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .position_o      (position_o),
    .step_delta_o    (step_delta_o),
    .tick_count_o    (tick_count_o),
    .speed_q4_o      (speed_q4_o),
    .speed_updated_o (speed_updated_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Tracker state as the block should hold it.
  logic [ept_pkg::FILL_W-1:0] win_len_setting;
  logic [ept_pkg::CPR_W-1:0]  cpr_setting;
  logic [ept_pkg::CNT_W-1:0]  trk_prev_count;
  logic [ept_pkg::POS_W-1:0]  trk_position;
  logic [ept_pkg::CNT_W-1:0]  trk_delta;
  logic [ept_pkg::CNT_W-1:0]  trk_ticks;
  longint                     trk_win_sum;
  int unsigned                trk_win_fill;
  logic [ept_pkg::SPD_W-1:0]  trk_speed;

  track_result_t due_results[$];
  stim_row_t     stim_rows[$];
  int            err_count = 0;
  int            mismatch_count = 0;
  int            holds_asked = 0;
  bit            gaps_on = 1'b1;
  int            burst_left = 0;

  function automatic void clear_tracking();
    trk_position = '0;
    trk_delta    = '0;
    trk_ticks    = '0;
    trk_speed    = '0;
    trk_win_sum  = 0;
    trk_win_fill = 0;
  endfunction

  function automatic logic [ept_pkg::SPD_W-1:0] window_speed(longint sum,
                                                            int unsigned fill);
    bit                         neg;
    longint unsigned            mag, d, lim, q, r, v;
    logic [ept_pkg::SPD_W-1:0]  v32;
    neg = sum < 0;
    mag = neg ? longint'(-sum) : longint'(sum);
    d   = longint'(fill) * longint'(cpr_setting);
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (d == 0) d = 1;
    q = mag / d;
    r = mag % d;
    if (q > lim / SPEED_SCALE) begin
      v = lim;
    end else begin
      v = q * SPEED_SCALE + (r * SPEED_SCALE) / d;
      if (v > lim) v = lim;
    end
    v32 = v[ept_pkg::SPD_W-1:0];
    return neg ? -v32 : v32;
  endfunction

  function automatic track_result_t track_request(logic [ept_pkg::REQ_W-1:0] req,
                                                  logic [ept_pkg::CNT_W-1:0] cnt);
    track_result_t             res;
    logic [ept_pkg::CNT_W-1:0] raw;
    logic                      updated;
    updated = 1'b0;
    case (req)
      ept_pkg::REQ_TICK: begin
        raw = cnt - trk_prev_count;
        trk_prev_count = cnt;
        trk_position = trk_position +
                       {{(ept_pkg::POS_W-ept_pkg::CNT_W){raw[ept_pkg::CNT_W-1]}}, raw};
        trk_delta = raw;
        trk_ticks = trk_ticks + 1'b1;
        trk_win_sum = trk_win_sum + $signed({{32{raw[ept_pkg::CNT_W-1]}}, raw});
        trk_win_fill = trk_win_fill + 1;
        if (trk_win_fill >= win_len_setting) begin
          trk_speed = window_speed(trk_win_sum, trk_win_fill);
          trk_win_sum = 0;
          trk_win_fill = 0;
          updated = 1'b1;
        end
      end
      ept_pkg::REQ_ZERO: begin
        clear_tracking();
      end
      ept_pkg::REQ_INIT: begin
        trk_prev_count = cnt;
        clear_tracking();
      end
      default: begin
      end
    endcase
    res.position      = trk_position;
    res.step_delta    = trk_delta;
    res.tick_count    = trk_ticks;
    res.speed_q4      = trk_speed;
    res.speed_updated = updated;
    return res;
  endfunction

  function automatic void apply_setting(logic [ept_pkg::CFG_IDX_W-1:0] idx,
                                        logic [ept_pkg::CFG_DATA_W-1:0] val);
    logic [ept_pkg::FILL_W-1:0] w;
    logic [ept_pkg::CPR_W-1:0]  c;
    if (idx == ept_pkg::CFG_WINDOW_LEN) begin
      w = val[ept_pkg::FILL_W-1:0];
      if (w == 0) w = 1;
      if (w > ept_pkg::MAX_WINDOW) w = ept_pkg::MAX_WINDOW;
      win_len_setting = w;
      trk_win_sum = 0;
      trk_win_fill = 0;
    end else begin
      c = val[ept_pkg::CPR_W-1:0];
      if (c == 0) c = 1;
      cpr_setting = c;
    end
  endfunction

  function automatic stim_row_t item_row(logic [ept_pkg::REQ_W-1:0] req,
                                         logic [ept_pkg::CNT_W-1:0] cnt);
    stim_row_t row;
    row = '{default: '0};
    row.req = req;
    row.count = cnt;
    return row;
  endfunction

  function automatic stim_row_t typed_row(logic [ept_pkg::REQ_W-1:0] req,
                                          logic [ept_pkg::CNT_W-1:0] cnt,
                                          logic [ept_pkg::POS_W-1:0] pos,
                                          logic [ept_pkg::CNT_W-1:0] dl,
                                          logic [ept_pkg::CNT_W-1:0] tc,
                                          logic [ept_pkg::SPD_W-1:0] sp,
                                          logic up);
    stim_row_t row;
    row = item_row(req, cnt);
    row.typed = 1'b1;
    row.res = '{pos, dl, tc, sp, up};
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic [ept_pkg::CFG_IDX_W-1:0] idx,
                                        logic [ept_pkg::CFG_DATA_W-1:0] val);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  task automatic drain_results();
    do @(negedge clk_i); while (due_results.size() != 0);
    @(posedge clk_i);
  endtask

  // Registers are only written once every pending result has been taken.
  task automatic set_register(logic [ept_pkg::CFG_IDX_W-1:0] idx,
                              logic [ept_pkg::CFG_DATA_W-1:0] val);
    in_valid_i <= 1'b0;
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_setting(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_request(logic [ept_pkg::REQ_W-1:0] req,
                              logic [ept_pkg::CNT_W-1:0] cnt,
                              bit typed, track_result_t typed_res);
    track_result_t res;
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    counter_value_i <= cnt;
    do @(posedge clk_i); while (in_stall_o);
    res = track_request(req, cnt);
    due_results.push_back(typed ? typed_res : res);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if (gaps_on) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  endtask

  always @(posedge clk_i) begin
    track_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        err_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transfer: pos %0d delta %0d ticks %0d speed %0d upd %0b",
                   position_o, step_delta_o, tick_count_o, speed_q4_o, speed_updated_o);
      end else begin
        want = due_results.pop_front();
        if (position_o !== want.position || step_delta_o !== want.step_delta ||
            tick_count_o !== want.tick_count || speed_q4_o !== want.speed_q4 ||
            speed_updated_o !== want.speed_updated) begin
          err_count++;
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch expected: pos %0d delta %0d ticks %0d speed %0d upd %0b",
                     want.position, want.step_delta, want.tick_count, want.speed_q4,
                     want.speed_updated);
            $display("         actual:   pos %0d delta %0d ticks %0d speed %0d upd %0b",
                     position_o, step_delta_o, tick_count_o, speed_q4_o, speed_updated_o);
          end
        end
      end
    end
  end

  // The receiver stalls on a rotating pattern and, when asked, holds off for a
  // long stretch so that the block fills up and stalls its input.
  int hold_left = 0;
  int holds_done = 0;
  int pat_left = 0;
  int pat_pos = 0;
  logic [31:0] stall_pat = '0;

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      if (pat_left == 0) begin
        pat_left = $urandom_range(20, 200);
        pat_pos = 0;
        case ($urandom_range(0, 3))
          0: stall_pat = '0;
          1: stall_pat = $urandom;
          2: stall_pat = $urandom & $urandom;
          default: stall_pat = $urandom | $urandom;
        endcase
      end
      out_stall_i <= stall_pat[pat_pos];
      pat_pos = (pat_pos + 1) % 32;
      pat_left--;
    end
  end

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    track_result_t              no_res;
    int                         items_sent;
    int                         phase;
    int                         n;
    int unsigned                step_max;
    logic [ept_pkg::FILL_W-1:0] win;
    logic [ept_pkg::CPR_W-1:0]  cpr;
    logic [ept_pkg::REQ_W-1:0]  req;
    logic [ept_pkg::CNT_W-1:0]  cnt;
    int unsigned                pick;

    no_res = '{default: '0};
    win_len_setting = ept_pkg::WINDOW_LEN_RST;
    cpr_setting     = ept_pkg::CPR_RST;
    trk_prev_count  = '0;
    clear_tracking();

    stim_rows.push_back(typed_row(ept_pkg::REQ_TICK, 32'h0000_0000, 64'd0, 32'd0, 32'd1,
                                  32'd0, 1'b0));
    stim_rows.push_back(typed_row(ept_pkg::REQ_TICK, 32'hFFFF_FFFF, '1, '1, 32'd2,
                                  32'd0, 1'b0));
    stim_rows.push_back(item_row(ept_pkg::REQ_TICK, 32'h7FFF_FFFF));
    stim_rows.push_back(item_row(ept_pkg::REQ_TICK, 32'h8000_0000));
    stim_rows.push_back(item_row(REQ_UNUSED, 32'h1234_5678));
    stim_rows.push_back(typed_row(ept_pkg::REQ_ZERO, 32'hFFFF_FFFF, 64'd0, 32'd0, 32'd0,
                                  32'd0, 1'b0));
    stim_rows.push_back(typed_row(ept_pkg::REQ_INIT, 32'hFFFF_FFFF, 64'd0, 32'd0, 32'd0,
                                  32'd0, 1'b0));
    stim_rows.push_back(typed_row(ept_pkg::REQ_TICK, 32'h0000_0000, 64'd1, 32'd1, 32'd1,
                                  32'd0, 1'b0));
    stim_rows.push_back(reg_row(ept_pkg::CFG_WINDOW_LEN, 24'h000000));
    stim_rows.push_back(reg_row(ept_pkg::CFG_COUNTS_PER_REV, 24'h000000));
    stim_rows.push_back(typed_row(ept_pkg::REQ_TICK, 32'h7FFF_FFFF, 64'h8000_0000,
                                  32'h7FFF_FFFF, 32'd2, 32'h7FFF_FFFF, 1'b1));
    stim_rows.push_back(typed_row(ept_pkg::REQ_TICK, 32'hFFFF_FFFF, 64'd0, 32'h8000_0000,
                                  32'd3, 32'h8000_0000, 1'b1));
    stim_rows.push_back(typed_row(ept_pkg::REQ_TICK, 32'hFFFF_FFFF, 64'd0, 32'd0, 32'd4,
                                  32'd0, 1'b1));
    stim_rows.push_back(reg_row(ept_pkg::CFG_WINDOW_LEN, 24'hABC3FF));
    stim_rows.push_back(reg_row(ept_pkg::CFG_COUNTS_PER_REV, 24'hFFFFFF));
    stim_rows.push_back(item_row(ept_pkg::REQ_TICK, 32'h0000_0000));
    stim_rows.push_back(item_row(ept_pkg::REQ_TICK, 32'h1234_5678));
    stim_rows.push_back(reg_row(ept_pkg::CFG_WINDOW_LEN, 24'h0003E8));
    stim_rows.push_back(item_row(ept_pkg::REQ_TICK, 32'h5555_AAAA));
    stim_rows.push_back(reg_row(ept_pkg::CFG_WINDOW_LEN, 24'hFFFC03));
    stim_rows.push_back(reg_row(ept_pkg::CFG_COUNTS_PER_REV, 24'h001000));
    stim_rows.push_back(item_row(ept_pkg::REQ_TICK, 32'h5555_B000));
    stim_rows.push_back(item_row(ept_pkg::REQ_TICK, 32'h5555_A000));
    stim_rows.push_back(item_row(ept_pkg::REQ_TICK, 32'h5555_C123));
    stim_rows.push_back(item_row(ept_pkg::REQ_INIT, 32'h0000_0000));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg)
        set_register(stim_rows[i].reg_idx, stim_rows[i].reg_val);
      else
        send_request(stim_rows[i].req, stim_rows[i].count, stim_rows[i].typed,
                     stim_rows[i].res);
    end

    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: win = 10'd0;
        1: win = 10'd1;
        2: win = 10'd1023;
        3: win = $urandom_range(17, 120);
        4: win = $urandom;
        default: win = $urandom_range(2, 16);
      endcase
      case ($urandom_range(0, 7))
        0: cpr = 24'd0;
        1: cpr = 24'd1;
        2: cpr = 24'hFFFFFF;
        3: cpr = $urandom;
        default: cpr = $urandom_range(100, 10000);
      endcase
      // Skipping the window write now and then lets a window span two phases.
      if (phase < 2 || $urandom_range(0, 3) != 0)
        set_register(ept_pkg::CFG_WINDOW_LEN, {14'($urandom), win});
      set_register(ept_pkg::CFG_COUNTS_PER_REV, cpr);

      gaps_on = $urandom_range(0, 3) != 0;
      if (phase == 1 || $urandom_range(0, 7) == 0) begin
        holds_asked++;
        gaps_on = 1'b0;
      end
      case ($urandom_range(0, 3))
        0: step_max = 3;
        1: step_max = 1000;
        2: step_max = 100000;
        default: step_max = 32'h4000_0000;
      endcase

      n = $urandom_range(30, 100);
      if (n > RANDOM_ITEMS - items_sent) n = RANDOM_ITEMS - items_sent;
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 88) req = ept_pkg::REQ_TICK;
        else if (pick < 92) req = ept_pkg::REQ_ZERO;
        else if (pick < 96) req = ept_pkg::REQ_INIT;
        else req = REQ_UNUSED;
        if (req != ept_pkg::REQ_TICK || $urandom_range(0, 9) == 0)
          cnt = $urandom;
        else
          cnt = trk_prev_count + ($urandom_range(0, 2 * step_max) - step_max);
        send_request(req, cnt, 1'b0, no_res);
        items_sent++;
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    if (due_results.size() != 0) err_count++;
    if (err_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/ept_pkg.sv
rtl/ept_addsub.sv
rtl/ept_speed_unit.sv
rtl/encoder_position_velocity_tracker_unit.sv
sim/tb_top.sv
